FILE: src/bcos_pkg.sv
`default_nettype none

package bcos_pkg;

    // Datapath widths (sized for up to 16 agents)
    localparam int VAL_W   = 16;   // Q4.12 opinion
    localparam int SUM_W   = 20;   // sum of up to 14 influences
    localparam int MA_W    = 21;   // multiplier operand A
    localparam int MB_W    = 17;   // multiplier operand B
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 56;
    localparam int SPLIT   = 19;   // low slice of acc for the two-pass multiply
    localparam int FIN_W   = 26;   // old value plus increment, before clamping
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic signed [VAL_W-1:0] UNIT_ONE = 16'sd4096;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PLAYER_GAIN  = 3'd0;
    localparam t_cfg_idx CFG_PLAYER_RANGE = 3'd1;
    localparam t_cfg_idx CFG_AGENT_GAIN   = 3'd2;
    localparam t_cfg_idx CFG_AGENT_RANGE  = 3'd3;
    localparam t_cfg_idx CFG_OPINION_MIN  = 3'd4;
    localparam t_cfg_idx CFG_OPINION_MAX  = 3'd5;
    localparam t_cfg_idx CFG_SHAPE        = 3'd6;

    // Control word fields
    typedef enum logic [1:0] {RA_ZERO, RA_I, RA_ONE, RA_JNEXT} t_ra;
    typedef enum logic [2:0] {MUL_NONE, MUL_SPEED, MUL_PG, MUL_AG, MUL_LO, MUL_HI} t_mul;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADDHI} t_accop;
    typedef enum logic [1:0] {SUM_HOLD, SUM_CLR, SUM_ACC} t_sumop;
    typedef enum logic [1:0] {CNT_HOLD, CNT_ONE, CNT_INC} t_cntop;
    typedef enum logic [1:0] {EMIT_NONE, EMIT_PLAYER, EMIT_AGENT} t_emit;
    typedef enum logic [2:0] {JC_NEXT, JC_ALWAYS, JC_START, JC_JMORE, JC_IMORE} t_jc;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_ra     ra;
        logic    lat_op0;
        logic    lat_opi;
        t_mul    mul;
        t_accop  acc;
        t_sumop  sum;
        t_cntop  jop;
        t_cntop  iop;
        t_emit   emit;
        logic    fin;
        t_jc     jc;
        t_pc     target;
    } t_uword;

    // Program labels
    localparam t_pc PC_IDLE = 4'd0;
    localparam t_pc PC_RD0  = 4'd1;
    localparam t_pc PC_P0   = 4'd2;
    localparam t_pc PC_P1   = 4'd3;
    localparam t_pc PC_P2   = 4'd4;
    localparam t_pc PC_A0   = 4'd5;
    localparam t_pc PC_A1   = 4'd6;
    localparam t_pc PC_J    = 4'd7;
    localparam t_pc PC_A3   = 4'd8;
    localparam t_pc PC_A4   = 4'd9;
    localparam t_pc PC_A5   = 4'd10;
    localparam t_pc PC_A6   = 4'd11;
    localparam t_pc PC_A7   = 4'd12;
    localparam t_pc PC_A8   = 4'd13;
    localparam t_pc PC_FIN  = 4'd14;

    localparam t_uword UW_NOP = '{
        ra: RA_ZERO, lat_op0: 1'b0, lat_opi: 1'b0, mul: MUL_NONE, acc: ACC_HOLD,
        sum: SUM_HOLD, jop: CNT_HOLD, iop: CNT_HOLD, emit: EMIT_NONE, fin: 1'b0,
        jc: JC_NEXT, target: PC_IDLE
    };

    // Control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            PC_IDLE: begin
                w.jc = JC_START;
                w.target = PC_RD0;
            end
            PC_RD0: w.ra = RA_ZERO;
            PC_P0: begin
                w.lat_op0 = 1'b1;
                w.mul = MUL_SPEED;
            end
            PC_P1: w.acc = ACC_LOAD;
            PC_P2: begin
                w.emit = EMIT_PLAYER;
                w.iop = CNT_ONE;
            end
            PC_A0: w.ra = RA_I;
            PC_A1: begin
                w.lat_opi = 1'b1;
                w.mul = MUL_PG;
                w.ra = RA_ONE;
                w.jop = CNT_ONE;
                w.sum = SUM_CLR;
            end
            PC_J: begin
                w.ra = RA_JNEXT;
                w.sum = SUM_ACC;
                w.jop = CNT_INC;
                w.jc = JC_JMORE;
                w.target = PC_J;
            end
            PC_A3: begin
                w.mul = MUL_AG;
                w.acc = ACC_LOAD;
            end
            PC_A4: w.acc = ACC_ADD;
            PC_A5: w.mul = MUL_LO;
            PC_A6: begin
                w.mul = MUL_HI;
                w.acc = ACC_LOAD;
            end
            PC_A7: w.acc = ACC_ADDHI;
            PC_A8: begin
                w.emit = EMIT_AGENT;
                w.iop = CNT_INC;
                w.jc = JC_IMORE;
                w.target = PC_A0;
            end
            PC_FIN: begin
                w.fin = 1'b1;
                w.jc = JC_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.jc = JC_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/bcos_ram.sv
`default_nettype none

module bcos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/bounded_confidence_opinion_step.sv
// Bounded-confidence opinion step.
// Holds one Q4.12 opinion per agent; agent 0 is the player.
// Input stream (s_*): s_tuser selects the operation (0 load, 1 step).
//   Load writes one opinion and returns nothing; loads to an
//   index at or above NUM_AGENTS are dropped.
//   Step runs a microprogram over one shared 21x17 multiplier and the single
//   read port of the opinion memory. It emits NUM_AGENTS transactions on m_*
//   in index order, tlast on the final one.
// Step order: the player is updated first; for every other agent the
//   sequencer scans all other agents, one memory read each, then runs the
//   multiply/accumulate steps and emits, waiting while the output is held off.
// s_tready is high only while the sequencer is idle, so one item is worked
//   at a time. Results leave through a one-deep output register; when the
//   receiver stalls, the sequencer waits at its emit step and resumes when
//   the register frees up.
// Opinions live in a two-bank memory: a step reads the current bank and
//   writes the other, then swaps. Per-agent valid bits, cleared by reset,
//   make unwritten opinions read as zero, so no clearing pass is needed.
// Reset (synchronous, active low) returns configuration to defaults, clears
//   the opinions and idles the sequencer. Configuration writes take effect
//   at the edge where i_cfg_we is high and are meant for idle periods.
`default_nettype none

module bounded_confidence_opinion_step #(
    parameter int NUM_AGENTS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [bcos_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcos_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata, low bit up: agent_index[2:0], opinion_value[18:3],
    // player_speed[33:19], step_size[49:34], zero fill [55:50]
    input  wire logic [55:0]                    s_tdata,
    // tuser: operation
    input  wire logic                           s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata, low bit up: out_index[2:0], out_opinion[18:3], zero fill [23:19]
    output logic [23:0]                         m_tdata,
    output logic                                m_tlast
);

    localparam int IW    = $clog2(NUM_AGENTS);
    localparam int DEPTH = 2 << IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_AGENTS - 1);
    localparam logic signed [bcos_pkg::ACC_W-1:0] RND16 = 56'sh8000;
    localparam logic signed [bcos_pkg::ACC_W-1:0] RND32 = 56'sh80000000;

    // Configuration registers
    logic [15:0]        r_pgain;
    logic [14:0]        r_prange;
    logic [15:0]        r_again;
    logic [14:0]        r_arange;
    logic signed [15:0] r_omin;
    logic signed [15:0] r_omax;
    logic [1:0]         r_shape;

    // Sequencer and datapath state
    bcos_pkg::t_pc      r_pc;
    bcos_pkg::t_pc      n_pc;
    bcos_pkg::t_uword   w_uw;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic               r_bank;
    logic [(1<<IW)-1:0] r_valid;
    logic               r_rd_vld;
    logic signed [15:0] r_op0;
    logic signed [15:0] r_opi;
    logic [15:0]        r_step;
    logic signed [14:0] r_speed;
    logic signed [bcos_pkg::SUM_W-1:0]  r_sum;
    logic signed [bcos_pkg::PROD_W-1:0] r_prod;
    logic signed [bcos_pkg::ACC_W-1:0]  r_acc;

    // Output register
    logic               r_out_valid;
    logic [2:0]         r_out_idx;
    logic [15:0]        r_out_op;
    logic               r_out_last;

    logic               w_accept;
    logic               w_start;
    logic               w_load_ok;
    logic [4:0]         w_ld_idx5;
    logic [IW-1:0]      w_ld_idx;
    logic               w_stall;
    logic               w_adv;
    logic [IW-1:0]      w_ridx;
    logic [IW:0]        w_raddr;
    logic [15:0]        w_ram_q;
    logic signed [15:0] w_rd;
    logic signed [15:0] w_ip;
    logic signed [15:0] w_ia;
    logic signed [bcos_pkg::MA_W-1:0]   w_ma;
    logic signed [bcos_pkg::MB_W-1:0]   w_mb;
    logic signed [bcos_pkg::PROD_W-1:0] w_prod;
    logic signed [bcos_pkg::ACC_W-1:0]  w_prod_x;
    logic signed [bcos_pkg::ACC_W-1:0]  w_prod_hi;
    logic signed [15:0] w_new;
    logic [IW-1:0]      w_eidx;
    logic [4:0]         w_eidx5;
    logic               w_we;
    logic [IW:0]        w_waddr;
    logic [15:0]        w_wdata;

    // |a-b| <= range gives a-b (bounded) or 1.0 (uniform), else zero
    function automatic logic signed [15:0] infl(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [14:0]        range,
        input logic               uni
    );
        logic signed [16:0] d;
        logic [16:0]        mag;
        d   = {a[15], a} - {b[15], b};
        mag = d[16] ? 17'(-d) : 17'(d);
        if (mag <= {2'b00, range}) begin
            return uni ? bcos_pkg::UNIT_ONE : signed'(d[15:0]);
        end
        return '0;
    endfunction

    assign w_uw     = bcos_pkg::ucode(r_pc);
    assign s_tready = (r_pc == bcos_pkg::PC_IDLE);
    assign w_accept = s_tvalid & s_tready;
    assign w_start  = w_accept & s_tuser;

    assign w_ld_idx5 = {2'b00, s_tdata[2:0]};
    assign w_ld_idx  = w_ld_idx5[IW-1:0];
    assign w_load_ok = w_accept & ~s_tuser & (w_ld_idx5 < 5'(NUM_AGENTS));

    // Emit steps wait while the output register is full and not draining
    assign w_stall = (w_uw.emit != bcos_pkg::EMIT_NONE) & r_out_valid & ~m_tready;
    assign w_adv   = ~w_stall;

    // Memory read side
    always_comb begin
        unique case (w_uw.ra)
            bcos_pkg::RA_ZERO:  w_ridx = '0;
            bcos_pkg::RA_I:     w_ridx = r_i;
            bcos_pkg::RA_ONE:   w_ridx = IW'(1);
            bcos_pkg::RA_JNEXT: w_ridx = r_j + IW'(1);
            default:            w_ridx = '0;
        endcase
    end

    assign w_raddr = {r_bank, w_ridx};
    assign w_rd    = r_rd_vld ? signed'(w_ram_q) : '0;

    assign w_ip = infl(r_op0, w_rd, r_prange, r_shape[0]);
    assign w_ia = infl(w_rd, r_opi, r_arange, r_shape[1]);

    // Shared multiplier
    always_comb begin
        unique case (w_uw.mul)
            bcos_pkg::MUL_SPEED: begin
                w_ma = {{6{r_speed[14]}}, r_speed};
                w_mb = {1'b0, r_step};
            end
            bcos_pkg::MUL_PG: begin
                w_ma = {5'b0, r_pgain};
                w_mb = {w_ip[15], w_ip};
            end
            bcos_pkg::MUL_AG: begin
                w_ma = {r_sum[bcos_pkg::SUM_W-1], r_sum};
                w_mb = {1'b0, r_again};
            end
            bcos_pkg::MUL_LO: begin
                w_ma = {2'b00, r_acc[bcos_pkg::SPLIT-1:0]};
                w_mb = {1'b0, r_step};
            end
            bcos_pkg::MUL_HI: begin
                w_ma = {{3{r_acc[36]}}, r_acc[36:bcos_pkg::SPLIT]};
                w_mb = {1'b0, r_step};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod    = w_ma * w_mb;
    assign w_prod_x  = {{(bcos_pkg::ACC_W - bcos_pkg::PROD_W){r_prod[bcos_pkg::PROD_W-1]}},
                        r_prod};
    assign w_prod_hi = w_prod_x <<< bcos_pkg::SPLIT;

    // Round, add to the old opinion, clamp high then low
    always_comb begin
        logic signed [bcos_pkg::ACC_W-1:0] rnd;
        logic signed [bcos_pkg::ACC_W-1:0] sh;
        logic signed [bcos_pkg::FIN_W-1:0] v;
        logic signed [bcos_pkg::FIN_W-1:0] lo;
        logic signed [bcos_pkg::FIN_W-1:0] hi;
        logic signed [15:0]                base;
        logic                              ply;
        ply  = (w_uw.emit == bcos_pkg::EMIT_PLAYER);
        rnd  = r_acc + (ply ? RND16 : RND32);
        sh   = ply ? (rnd >>> 16) : (rnd >>> 32);
        base = ply ? r_op0 : r_opi;
        v    = {{10{base[15]}}, base} + signed'(sh[bcos_pkg::FIN_W-1:0]);
        hi   = {{10{r_omax[15]}}, r_omax};
        lo   = {{10{r_omin[15]}}, r_omin};
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        w_new = v[15:0];
    end

    assign w_eidx  = (w_uw.emit == bcos_pkg::EMIT_AGENT) ? r_i : '0;
    assign w_eidx5 = 5'(w_eidx);

    // Memory write side: loads go to the live bank, step results to the other
    always_comb begin
        priority if (w_load_ok) begin
            w_we    = 1'b1;
            w_waddr = {r_bank, w_ld_idx};
            w_wdata = s_tdata[18:3];
        end else begin
            w_we    = (w_uw.emit != bcos_pkg::EMIT_NONE) & w_adv;
            w_waddr = {~r_bank, w_eidx};
            w_wdata = w_new;
        end
    end

    bcos_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Next step address
    always_comb begin
        n_pc = r_pc;
        if (w_adv) begin
            unique case (w_uw.jc)
                bcos_pkg::JC_NEXT:   n_pc = r_pc + 4'd1;
                bcos_pkg::JC_ALWAYS: n_pc = w_uw.target;
                bcos_pkg::JC_START:  n_pc = w_start ? w_uw.target : r_pc;
                bcos_pkg::JC_JMORE:  n_pc = (r_j != LAST_IDX) ? w_uw.target : r_pc + 4'd1;
                bcos_pkg::JC_IMORE:  n_pc = (r_i != LAST_IDX) ? w_uw.target : r_pc + 4'd1;
                default:             n_pc = bcos_pkg::PC_IDLE;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= bcos_pkg::PC_IDLE;
            r_bank      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pgain     <= 16'd32768;
            r_prange    <= 15'd2048;
            r_again     <= 16'd3277;
            r_arange    <= 15'd0;
            r_omin      <= 16'sd0;
            r_omax      <= 16'sd16384;
            r_shape     <= 2'd0;
        end else begin
            r_pc <= n_pc;
            if (w_load_ok) begin
                r_valid[w_ld_idx] <= 1'b1;
            end
            if (w_adv && w_uw.fin) begin
                r_bank  <= ~r_bank;
                r_valid <= '1;
            end
            if (w_adv && (w_uw.emit != bcos_pkg::EMIT_NONE)) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bcos_pkg::CFG_PLAYER_GAIN:  r_pgain  <= i_cfg_data;
                    bcos_pkg::CFG_PLAYER_RANGE: r_prange <= i_cfg_data[14:0];
                    bcos_pkg::CFG_AGENT_GAIN:   r_again  <= i_cfg_data;
                    bcos_pkg::CFG_AGENT_RANGE:  r_arange <= i_cfg_data[14:0];
                    bcos_pkg::CFG_OPINION_MIN:  r_omin   <= signed'(i_cfg_data);
                    bcos_pkg::CFG_OPINION_MAX:  r_omax   <= signed'(i_cfg_data);
                    bcos_pkg::CFG_SHAPE:        r_shape  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[w_ridx];
        if (w_start) begin
            r_speed <= signed'(s_tdata[33:19]);
            r_step  <= s_tdata[49:34];
        end
        if (w_adv) begin
            if (w_uw.lat_op0) begin
                r_op0 <= w_rd;
            end
            if (w_uw.lat_opi) begin
                r_opi <= w_rd;
            end
            if (w_uw.mul != bcos_pkg::MUL_NONE) begin
                r_prod <= w_prod;
            end
            unique case (w_uw.acc)
                bcos_pkg::ACC_LOAD:  r_acc <= w_prod_x;
                bcos_pkg::ACC_ADD:   r_acc <= r_acc + w_prod_x;
                bcos_pkg::ACC_ADDHI: r_acc <= r_acc + w_prod_hi;
                default: ;
            endcase
            unique case (w_uw.sum)
                bcos_pkg::SUM_CLR: r_sum <= '0;
                bcos_pkg::SUM_ACC: begin
                    if (r_j != r_i) begin
                        r_sum <= r_sum + {{4{w_ia[15]}}, w_ia};
                    end
                end
                default: ;
            endcase
            unique case (w_uw.jop)
                bcos_pkg::CNT_ONE: r_j <= IW'(1);
                bcos_pkg::CNT_INC: r_j <= r_j + IW'(1);
                default: ;
            endcase
            unique case (w_uw.iop)
                bcos_pkg::CNT_ONE: r_i <= IW'(1);
                bcos_pkg::CNT_INC: r_i <= r_i + IW'(1);
                default: ;
            endcase
            if (w_uw.emit != bcos_pkg::EMIT_NONE) begin
                r_out_idx  <= w_eidx5[2:0];
                r_out_op   <= w_new;
                r_out_last <= (w_eidx == LAST_IDX);
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b0, r_out_op, r_out_idx};
    assign m_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: bench/bounded_confidence_opinion_step_test.sv
module bounded_confidence_opinion_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcos_pkg::*;

    localparam int AGENTS       = 8;
    localparam int RANDOM_ITEMS = 290;
    localparam int CYCLE_LIMIT  = 400000;
    // Extra wait after the last expected result, before the final verdict.
    localparam int DRAIN_CYCLES = 120;
    // A load is written at its accepting edge; no result marks its end.
    localparam int SETTLE_CYCLES = 8;

    // Index with no register behind it; writes there must change nothing.
    localparam t_cfg_idx CFG_SPARE = 3'd7;

    typedef enum logic {OP_LOAD = 1'b0, OP_STEP = 1'b1} op_t;

    // One input transaction, field by field
    typedef struct {
        op_t                op;
        logic [2:0]         agent;
        logic signed [15:0] value;
        logic signed [14:0] speed;
        logic [15:0]        step;
    } work_item_t;

    // One result transaction
    typedef struct {
        logic [2:0]         index;
        logic signed [15:0] opinion;
        logic               last;
    } opinion_out_t;

    // Shadow of the opinion memory and the registers; predicts every step.
    class opinion_scoreboard;
        int           opinion [AGENTS];
        int           player_gain;
        int           player_range;
        int           agent_gain;
        int           agent_range;
        int           floor_bound;
        int           ceil_bound;
        int           shape;
        opinion_out_t expected_opinions [$];
        int           errors;

        function new();
            player_gain  = 32768;
            player_range = 2048;
            agent_gain   = 3277;
            agent_range  = 0;
            floor_bound  = 0;
            ceil_bound   = 16384;
            shape        = 0;
            errors       = 0;
            foreach (opinion[i]) opinion[i] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_PLAYER_GAIN:  player_gain  = data;
                CFG_PLAYER_RANGE: player_range = data[14:0];
                CFG_AGENT_GAIN:   agent_gain   = data;
                CFG_AGENT_RANGE:  agent_range  = data[14:0];
                CFG_OPINION_MIN:  floor_bound  = $signed(data);
                CFG_OPINION_MAX:  ceil_bound   = $signed(data);
                CFG_SHAPE:        shape        = data[1:0];
                default: ;
            endcase
        endfunction

        // bounded confidence: the difference itself; uniform: 1.0 in Q4.12
        function int pull(int d, int range, bit uniform);
            int a;
            a = (d < 0) ? -d : d;
            if (a <= range) return uniform ? 4096 : d;
            return 0;
        endfunction

        // upper bound first, lower bound last: inverted bounds give floor_bound
        function int bound(longint v);
            if (v > ceil_bound) v = ceil_bound;
            if (v < floor_bound) v = floor_bound;
            return int'(v);
        endfunction

        function void take_item(work_item_t it);
            int           prior [AGENTS];
            longint       acc;
            longint       asum;
            int           stp;
            int           spd;
            opinion_out_t r;
            if (it.op == OP_LOAD) begin
                opinion[it.agent] = it.value;
                return;
            end
            stp = it.step;
            spd = it.speed;
            prior = opinion;
            // player: speed * step in Q4.28, rounded to Q4.12
            acc = longint'(spd) * stp;
            opinion[0] = bound(prior[0] + ((acc + 32768) >>> 16));
            // other agents: gains in Q0.16 times influence, times step, Q4.44
            for (int i = 1; i < AGENTS; i++) begin
                acc = longint'(player_gain) * pull(prior[0] - prior[i], player_range, shape[0]);
                asum = 0;
                for (int j = 1; j < AGENTS; j++)
                    if (j != i) asum += pull(prior[j] - prior[i], agent_range, shape[1]);
                acc += longint'(agent_gain) * asum;
                acc *= stp;
                opinion[i] = bound(prior[i] + ((acc + (longint'(1) <<< 31)) >>> 32));
            end
            for (int i = 0; i < AGENTS; i++) begin
                r.index   = i;
                r.opinion = opinion[i];
                r.last    = (i == AGENTS - 1);
                expected_opinions.push_back(r);
            end
        endfunction

        function void check_opinion(logic [2:0] index, logic signed [15:0] value, logic last);
            opinion_out_t e;
            if (expected_opinions.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: index %0d opinion %0d last %0b",
                         $time, index, value, last);
                return;
            end
            e = expected_opinions.pop_front();
            if (index !== e.index) begin
                errors++;
                $display("%0t: index mismatch: expected %0d actual %0d", $time, e.index, index);
            end
            if (value !== e.opinion) begin
                errors++;
                $display("%0t: opinion mismatch at agent %0d: expected %0d actual %0d",
                         $time, e.index, e.opinion, value);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: tlast mismatch at agent %0d: expected %0b actual %0b",
                         $time, e.index, e.last, last);
            end
        endfunction

        function int pending();
            return expected_opinions.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // agent_index[2:0], opinion_value[18:3], player_speed[33:19], step_size[49:34]
    logic [55:0]          s_tdata;
    // operation
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // out_index[2:0], out_opinion[18:3]
    logic [23:0]          m_tdata;
    logic                 m_tlast;

    opinion_scoreboard sb = new();

    // gap control: a calm side never idles, giving back-to-back stretches
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int items_sent = 0;
    int cycles;

    bounded_confidence_opinion_step #(
        .NUM_AGENTS(AGENTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v;
    endfunction

    // load transaction; the step fields carry junk the block must ignore
    function automatic work_item_t load_of(int agent, int value);
        work_item_t it;
        it.op    = OP_LOAD;
        it.agent = agent;
        it.value = value;
        it.speed = $urandom;
        it.step  = $urandom;
        return it;
    endfunction

    // step transaction; agent and value are junk
    function automatic work_item_t step_of(int speed, int step);
        work_item_t it;
        it.op    = OP_STEP;
        it.agent = $urandom;
        it.value = $urandom;
        it.speed = speed;
        it.step  = step;
        return it;
    endfunction

    function automatic work_item_t random_step();
        int stp;
        case ($urandom_range(0, 5))
            0:       stp = 0;
            1:       stp = 65535;
            2:       stp = $urandom_range(0, 255);
            default: stp = $urandom_range(0, 65535);
        endcase
        return step_of(span(-12288, 12288), stp);
    endfunction

    // Called at a rising edge; returns at the accepting edge with tvalid still
    // high so a zero-gap follower keeps it asserted.
    task automatic send_item(work_item_t it);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {6'b0, it.step, it.speed, it.value, it.agent};
        do @(posedge i_clk); while (!s_tready);
        sb.take_item(it);
        items_sent++;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // drop tvalid and let every expected transaction drain before a cfg write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic randomize_config();
        logic [15:0] lo;
        logic [15:0] hi;
        cfg_write(CFG_PLAYER_GAIN, ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF) : 16'($urandom));
        cfg_write(CFG_AGENT_GAIN, ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF) : 16'($urandom));
        case ($urandom_range(0, 3))
            0:       cfg_write(CFG_PLAYER_RANGE, 16'd0);
            1:       cfg_write(CFG_PLAYER_RANGE, 16'h7FFF);
            default: cfg_write(CFG_PLAYER_RANGE, 16'($urandom_range(0, 8192)));
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(CFG_AGENT_RANGE, 16'd0);
            1:       cfg_write(CFG_AGENT_RANGE, 16'h7FFF);
            default: cfg_write(CFG_AGENT_RANGE, 16'($urandom_range(0, 8192)));
        endcase
        // bounds: full span, random ordered pair, inverted pair, power-up pair
        case ($urandom_range(0, 4))
            0: begin lo = 16'h8000; hi = 16'h7FFF; end
            1: begin lo = 16'($signed(span(-32768, 0))); hi = 16'($signed(span(0, 32767))); end
            2: begin lo = 16'($signed(span(0, 8192))); hi = 16'($signed(span(-8192, -1))); end
            default: begin lo = 16'd0; hi = 16'd16384; end
        endcase
        cfg_write(CFG_OPINION_MIN, lo);
        cfg_write(CFG_OPINION_MAX, hi);
        cfg_write(CFG_SHAPE, 16'($urandom_range(0, 3)));
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random backpressure, each result checked at its accepting edge.
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_opinion(m_tdata[2:0], m_tdata[18:3], m_tlast);
            if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int start;
        int phase_start;
        int center;
        int spread;
        int kind;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_PLAYER_GAIN;
        i_cfg_data <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= OP_LOAD;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, power-up registers ---
        // step from the cleared memory, player at full speed and step
        send_item(step_of(12288, 65535));
        // opinion extremes, and two agents sharing a value (zero difference)
        send_item(load_of(0, 32767));
        send_item(load_of(1, -32768));
        send_item(load_of(2, 4096));
        send_item(load_of(3, 4096));
        send_item(load_of(4, 5000));
        send_item(load_of(5, 3000));
        send_item(load_of(6, 16384));
        send_item(load_of(7, 0));
        send_item(step_of(-12288, 65535));
        send_item(step_of(0, 0));

        // --- directed, register extremes with uniform influence on both ---
        settle();
        cfg_write(CFG_PLAYER_GAIN, 16'hFFFF);
        cfg_write(CFG_AGENT_GAIN, 16'hFFFF);
        cfg_write(CFG_PLAYER_RANGE, 16'h7FFF);
        cfg_write(CFG_AGENT_RANGE, 16'h7FFF);
        cfg_write(CFG_OPINION_MIN, 16'h8000);
        cfg_write(CFG_OPINION_MAX, 16'h7FFF);
        cfg_write(CFG_SHAPE, 16'd3);
        cfg_write(CFG_SPARE, 16'hFFFF);
        i_cfg_we <= 1'b0;
        send_item(load_of(0, -32768));
        send_item(load_of(7, 32767));
        send_item(step_of(12288, 65535));
        send_item(step_of(-1, 1));

        // --- directed, inverted bounds and zero ranges ---
        settle();
        cfg_write(CFG_OPINION_MIN, 16'd8192);
        cfg_write(CFG_OPINION_MAX, -16'sd8192);
        cfg_write(CFG_PLAYER_RANGE, 16'd0);
        cfg_write(CFG_AGENT_RANGE, 16'd0);
        cfg_write(CFG_SHAPE, 16'd1);
        i_cfg_we <= 1'b0;
        // everything collapses to the lower bound, then equal opinions meet a
        // zero range: uniform player pull counts, bounded agent pull is zero
        send_item(step_of(5000, 40000));
        send_item(step_of(-5000, 40000));
        settle();
        cfg_write(CFG_SHAPE, 16'd2);
        cfg_write(CFG_OPINION_MIN, 16'h8000);
        cfg_write(CFG_OPINION_MAX, 16'h7FFF);
        i_cfg_we <= 1'b0;
        send_item(step_of(0, 65535));

        // --- random phases ---
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            settle();
            randomize_config();
            phase_start = items_sent;
            while (items_sent - phase_start < 40 && items_sent - start < RANDOM_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6) begin
                    // full reload with a clustered population, then a few steps
                    center = span(-16384, 16384);
                    spread = $urandom_range(0, 4096);
                    for (int a = 0; a < AGENTS; a++)
                        send_item(load_of(a, clip16(center + span(-spread, spread))));
                    repeat ($urandom_range(1, 4)) send_item(random_step());
                end else if (kind <= 8) begin
                    send_item(load_of($urandom_range(0, AGENTS - 1), span(-32768, 32767)));
                end else begin
                    send_item(random_step());
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
